>>> rtl/core/dcl_pkg.sv
// shared types, codes and helpers for the dhcp client lease block
package dcl_pkg;

    // most results one transaction can produce, status included
    localparam int unsigned NumRes = 6;
    localparam int unsigned CntW   = $clog2(NumRes + 1);

    // request codes
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_MSG   = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    // dhcp message types
    localparam logic [7:0] MSG_OFFER = 8'd2;
    localparam logic [7:0] MSG_ACK   = 8'd5;
    localparam logic [7:0] MSG_NAK   = 8'd6;

    // result action codes
    localparam logic [3:0] ACT_STATUS    = 4'd0;
    localparam logic [3:0] ACT_DISCOVER  = 4'd1;
    localparam logic [3:0] ACT_REQUEST   = 4'd2;
    localparam logic [3:0] ACT_ADD_ADDR  = 4'd3;
    localparam logic [3:0] ACT_ADD_ROUTE = 4'd4;
    localparam logic [3:0] ACT_DEL_ADDR  = 4'd5;
    localparam logic [3:0] ACT_DEL_ROUTE = 4'd6;
    localparam logic [3:0] ACT_EXISTS    = 4'd7;
    localparam logic [3:0] ACT_NOT_FOUND = 4'd8;

    // timer arm bits
    localparam int unsigned ARM_T1  = 0;
    localparam int unsigned ARM_T2  = 1;
    localparam int unsigned ARM_EXP = 2;

    localparam logic [5:0] MAX_PREFIX = 6'd32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  msg_kind;
        logic        parse_ok;
        logic [31:0] msg_server_ip;
        logic [31:0] msg_your_ip;
        logic [5:0]  msg_prefix_len;
        logic [31:0] msg_router_ip;
        logic [31:0] msg_lease_secs;
        logic [31:0] msg_renew_secs;
        logic [31:0] msg_rebind_secs;
        logic [31:0] fresh_xid;
    } t_item;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] xid;
        logic [31:0] addr;
        logic [31:0] server;
        logic [5:0]  prefix_len;
        logic [2:0]  state;
        logic [31:0] lease_secs;
        logic        last;
    } t_result;

    function automatic t_result mk_res(
        input logic [3:0]  action,
        input logic [31:0] xid,
        input logic [31:0] addr,
        input logic [31:0] server,
        input logic [5:0]  prefix_len,
        input logic [2:0]  state,
        input logic [31:0] lease_secs,
        input logic        last
    );
        t_result r;
        r.action     = action;
        r.xid        = xid;
        r.addr       = addr;
        r.server     = server;
        r.prefix_len = prefix_len;
        r.state      = state;
        r.lease_secs = lease_secs;
        r.last       = last;
        return r;
    endfunction

endpackage

>>> rtl/core/dcl_lease_core.sv
// lease state registers and the one-pass next-state and result logic
module dcl_lease_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  dcl_pkg::t_item              i_item,
    output dcl_pkg::t_result            o_slot [dcl_pkg::NumRes],
    output logic [dcl_pkg::CntW-1:0]    o_cnt
);

    typedef enum logic [2:0] {
        ST_IDLE       = 3'd0,
        ST_INIT       = 3'd1,
        ST_SELECTING  = 3'd2,
        ST_REQUESTING = 3'd3,
        ST_BOUND      = 3'd4,
        ST_RENEWING   = 3'd5,
        ST_REBINDING  = 3'd6
    } t_fsm;

    t_fsm        r_state,  n_state;
    logic [31:0] r_xid,    n_xid;
    logic [31:0] r_server, n_server;
    logic [31:0] r_addr,   n_addr;
    logic [31:0] r_router, n_router;
    logic [5:0]  r_plen,   n_plen;
    logic [31:0] r_lease,  n_lease;
    logic [31:0] r_renew,  n_renew;
    logic [31:0] r_rebind, n_rebind;
    logic [31:0] r_t1,     n_t1;
    logic [31:0] r_t2,     n_t2;
    logic [31:0] r_exp,    n_exp;
    logic [2:0]  r_armed,  n_armed;

    // default timer loads come straight from the message being handled
    logic [34:0] lease_x7;
    logic [31:0] t1_load;
    logic [31:0] t2_load;
    logic [5:0]  plen_sat;

    assign lease_x7 = {i_item.msg_lease_secs, 3'b000} - {3'b000, i_item.msg_lease_secs};
    assign t1_load  = (i_item.msg_renew_secs == 32'd0) ? (i_item.msg_lease_secs >> 1)
                                                       : i_item.msg_renew_secs;
    assign t2_load  = (i_item.msg_rebind_secs == 32'd0) ? lease_x7[34:3]
                                                        : i_item.msg_rebind_secs;
    assign plen_sat = (i_item.msg_prefix_len > dcl_pkg::MAX_PREFIX) ? dcl_pkg::MAX_PREFIX
                                                                    : i_item.msg_prefix_len;

    always_comb begin
        logic [dcl_pkg::CntW-1:0] k;
        logic                     fire;
        logic                     drop;

        n_state  = r_state;
        n_xid    = r_xid;
        n_server = r_server;
        n_addr   = r_addr;
        n_router = r_router;
        n_plen   = r_plen;
        n_lease  = r_lease;
        n_renew  = r_renew;
        n_rebind = r_rebind;
        n_t1     = r_t1;
        n_t2     = r_t2;
        n_exp    = r_exp;
        n_armed  = r_armed;
        k        = '0;
        fire     = 1'b0;
        drop     = 1'b0;
        for (int i = 0; i < dcl_pkg::NumRes; i++) begin
            o_slot[i] = '0;
        end

        case (i_item.req_type)
            dcl_pkg::REQ_START: begin
                if (r_state != ST_IDLE) begin
                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_EXISTS, '0, '0, '0, '0, '0, '0,
                                                1'b0);
                    k = k + 1'b1;
                end else begin
                    n_server = '0;
                    n_addr   = '0;
                    n_router = '0;
                    n_plen   = '0;
                    n_lease  = '0;
                    n_renew  = '0;
                    n_rebind = '0;
                    n_t1     = '0;
                    n_t2     = '0;
                    n_exp    = '0;
                    n_armed  = '0;
                    n_xid    = i_item.fresh_xid;
                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DISCOVER, n_xid, '0, '0, '0, '0,
                                                '0, 1'b0);
                    k = k + 1'b1;
                    n_state = ST_SELECTING;
                end
            end
            dcl_pkg::REQ_STOP: begin
                if (r_state == ST_IDLE) begin
                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_NOT_FOUND, '0, '0, '0, '0, '0,
                                                '0, 1'b0);
                    k = k + 1'b1;
                end else begin
                    if (r_addr != '0 && r_plen != '0) begin
                        o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DEL_ADDR, '0, r_addr, '0,
                                                    r_plen, '0, '0, 1'b0);
                        k = k + 1'b1;
                    end
                    if (r_router != '0) begin
                        o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DEL_ROUTE, '0, r_router,
                                                    '0, '0, '0, '0, 1'b0);
                        k = k + 1'b1;
                    end
                    n_state  = ST_IDLE;
                    n_xid    = '0;
                    n_server = '0;
                    n_addr   = '0;
                    n_router = '0;
                    n_plen   = '0;
                    n_lease  = '0;
                    n_renew  = '0;
                    n_rebind = '0;
                    n_t1     = '0;
                    n_t2     = '0;
                    n_exp    = '0;
                    n_armed  = '0;
                end
            end
            dcl_pkg::REQ_MSG: begin
                if (r_state != ST_IDLE && i_item.parse_ok) begin
                    // lease fields latch on every good message
                    n_server = i_item.msg_server_ip;
                    n_addr   = i_item.msg_your_ip;
                    n_plen   = plen_sat;
                    n_router = i_item.msg_router_ip;
                    n_lease  = i_item.msg_lease_secs;
                    n_renew  = i_item.msg_renew_secs;
                    n_rebind = i_item.msg_rebind_secs;
                    unique case (r_state)
                        ST_SELECTING: begin
                            if (i_item.msg_kind == dcl_pkg::MSG_OFFER && n_server != '0 &&
                                n_addr != '0) begin
                                o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_REQUEST, r_xid,
                                                            n_addr, n_server, '0, '0, '0,
                                                            1'b0);
                                k = k + 1'b1;
                                n_state = ST_REQUESTING;
                            end
                        end
                        ST_REQUESTING: begin
                            if (i_item.msg_kind == dcl_pkg::MSG_ACK) begin
                                if (n_addr != '0 && n_plen != '0) begin
                                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_ADD_ADDR, '0,
                                                                n_addr, '0, n_plen, '0, '0,
                                                                1'b0);
                                    k = k + 1'b1;
                                    if (n_router != '0) begin
                                        o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_ADD_ROUTE,
                                                                    '0, n_router, '0, '0,
                                                                    '0, '0, 1'b0);
                                        k = k + 1'b1;
                                    end
                                    n_state = ST_BOUND;
                                    n_t1    = t1_load;
                                    n_t2    = t2_load;
                                    n_exp   = i_item.msg_lease_secs;
                                    n_armed = 3'b111;
                                end
                            end else if (i_item.msg_kind == dcl_pkg::MSG_NAK) begin
                                n_state = ST_INIT;
                            end
                        end
                        ST_RENEWING, ST_REBINDING: begin
                            if (i_item.msg_kind == dcl_pkg::MSG_ACK) begin
                                n_state = ST_BOUND;
                                n_t1    = t1_load;
                                n_t2    = t2_load;
                                n_exp   = i_item.msg_lease_secs;
                                n_armed = 3'b111;
                            end else if (i_item.msg_kind == dcl_pkg::MSG_NAK) begin
                                n_armed = '0;
                                n_t1    = '0;
                                n_t2    = '0;
                                n_exp   = '0;
                                drop    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // one-second tick: T1, T2, then expiry
                fire = r_armed[dcl_pkg::ARM_T1] && r_t1 <= 32'd1;
                if (fire) begin
                    n_t1 = '0;
                    n_armed[dcl_pkg::ARM_T1] = 1'b0;
                end else if (r_armed[dcl_pkg::ARM_T1]) begin
                    n_t1 = r_t1 - 32'd1;
                end
                if (fire && n_state == ST_BOUND) begin
                    n_state = ST_RENEWING;
                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_REQUEST, r_xid, r_addr, r_server,
                                                '0, '0, '0, 1'b0);
                    k = k + 1'b1;
                end
                fire = r_armed[dcl_pkg::ARM_T2] && r_t2 <= 32'd1;
                if (fire) begin
                    n_t2 = '0;
                    n_armed[dcl_pkg::ARM_T2] = 1'b0;
                end else if (r_armed[dcl_pkg::ARM_T2]) begin
                    n_t2 = r_t2 - 32'd1;
                end
                if (fire && n_state == ST_RENEWING) begin
                    n_state = ST_REBINDING;
                    o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_REQUEST, r_xid, r_addr, r_server,
                                                '0, '0, '0, 1'b0);
                    k = k + 1'b1;
                end
                fire = r_armed[dcl_pkg::ARM_EXP] && r_exp <= 32'd1;
                if (fire) begin
                    n_exp = '0;
                    n_armed[dcl_pkg::ARM_EXP] = 1'b0;
                    drop = 1'b1;
                end else if (r_armed[dcl_pkg::ARM_EXP]) begin
                    n_exp = r_exp - 32'd1;
                end
            end
        endcase

        // lease lost: tear down what was installed and go back to discovery
        if (drop) begin
            if (n_addr != '0 && n_plen != '0) begin
                o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DEL_ADDR, '0, n_addr, '0, n_plen,
                                            '0, '0, 1'b0);
                k = k + 1'b1;
            end
            if (n_router != '0) begin
                o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DEL_ROUTE, '0, n_router, '0, '0,
                                            '0, '0, 1'b0);
                k = k + 1'b1;
            end
            n_server = '0;
            n_addr   = '0;
            n_plen   = '0;
            n_router = '0;
            n_xid    = i_item.fresh_xid;
            o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_DISCOVER, n_xid, '0, '0, '0, '0, '0,
                                        1'b0);
            k = k + 1'b1;
            n_state = ST_SELECTING;
        end

        o_slot[k] = dcl_pkg::mk_res(dcl_pkg::ACT_STATUS, '0, n_addr, n_server, '0, n_state,
                                    n_lease, 1'b1);
        o_cnt = k + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_xid    <= '0;
            r_server <= '0;
            r_addr   <= '0;
            r_router <= '0;
            r_plen   <= '0;
            r_lease  <= '0;
            r_renew  <= '0;
            r_rebind <= '0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_exp    <= '0;
            r_armed  <= '0;
        end else if (i_take) begin
            r_state  <= n_state;
            r_xid    <= n_xid;
            r_server <= n_server;
            r_addr   <= n_addr;
            r_router <= n_router;
            r_plen   <= n_plen;
            r_lease  <= n_lease;
            r_renew  <= n_renew;
            r_rebind <= n_rebind;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            r_exp    <= n_exp;
            r_armed  <= n_armed;
        end
    end

    // timers only run while a client exists
    a_armed_has_client: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_armed != 3'b000) |-> (r_state != ST_IDLE))
        else $error("timer armed with no client");

    a_start_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.req_type == dcl_pkg::REQ_START && r_state == ST_IDLE)
        |=> (r_state == ST_SELECTING && r_armed == 3'b000))
        else $error("start from idle did not enter selecting");

endmodule

>>> rtl/core/dcl_result_queue.sv
// result register bank: loads one transaction's results and shifts them out
module dcl_result_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  dcl_pkg::t_result            i_slot [dcl_pkg::NumRes],
    input  logic [dcl_pkg::CntW-1:0]    i_cnt,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dcl_pkg::t_result            o_res
);

    dcl_pkg::t_result         r_slot [dcl_pkg::NumRes];
    logic [dcl_pkg::CntW-1:0] r_cnt;
    logic                     pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    // free when empty, or once the final result leaves this cycle
    assign o_free  = (r_cnt == '0) || (pop && r_cnt == dcl_pkg::CntW'(1));
    assign o_res   = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_slot;
        end else if (pop) begin
            for (int i = 0; i < dcl_pkg::NumRes - 1; i++) begin
                r_slot[i] <= r_slot[i+1];
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= dcl_pkg::CntW'(dcl_pkg::NumRes))
        else $error("result count out of range");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> (r_cnt == dcl_pkg::CntW'(1)))
        else $error("last flag not on the final result");

endmodule

>>> rtl/core/dhcp_client_lease_fsm_unit.sv
// top level: dhcp client lease state machine with input register and result queue
// an accepted input waits in the input register until the result queue can load it
// each input transaction gives 1 to 6 results, which the result queue hands out one per
//   cycle while i_ready is high
// the input register takes the next transaction while results of the previous one drain
// reset: synchronous active-low i_rst_n returns the client to idle with all lease
//   fields, timers and arm bits zero and empties both the input register and the queue
module dhcp_client_lease_fsm_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_msg_kind,
    input  logic        i_parse_ok,
    input  logic [31:0] i_msg_server_ip,
    input  logic [31:0] i_msg_your_ip,
    input  logic [5:0]  i_msg_prefix_len,
    input  logic [31:0] i_msg_router_ip,
    input  logic [31:0] i_msg_lease_secs,
    input  logic [31:0] i_msg_renew_secs,
    input  logic [31:0] i_msg_rebind_secs,
    input  logic [31:0] i_fresh_xid,
    // result transaction channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_action,
    output logic [31:0] o_out_xid,
    output logic [31:0] o_out_addr,
    output logic [31:0] o_out_server,
    output logic [5:0]  o_out_prefix_len,
    output logic [2:0]  o_out_state,
    output logic [31:0] o_out_lease_secs,
    output logic        o_last
);

    // input register holding one accepted transaction
    logic                     r_in_valid;
    dcl_pkg::t_item           r_item;

    dcl_pkg::t_result         slot [dcl_pkg::NumRes];
    logic [dcl_pkg::CntW-1:0] cnt;
    logic                     q_free;
    logic                     take;
    dcl_pkg::t_result         res;

    // the held transaction moves on as soon as the queue can take its results
    assign take    = r_in_valid && q_free;
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.req_type        <= i_req_type;
            r_item.msg_kind        <= i_msg_kind;
            r_item.parse_ok        <= i_parse_ok;
            r_item.msg_server_ip   <= i_msg_server_ip;
            r_item.msg_your_ip     <= i_msg_your_ip;
            r_item.msg_prefix_len  <= i_msg_prefix_len;
            r_item.msg_router_ip   <= i_msg_router_ip;
            r_item.msg_lease_secs  <= i_msg_lease_secs;
            r_item.msg_renew_secs  <= i_msg_renew_secs;
            r_item.msg_rebind_secs <= i_msg_rebind_secs;
            r_item.fresh_xid       <= i_fresh_xid;
        end
    end

    // state update and result list in one pass
    dcl_lease_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (r_item),
        .o_slot  (slot),
        .o_cnt   (cnt)
    );

    // results go out one per cycle while i_ready is high, in order, status last
    dcl_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_slot  (slot),
        .i_cnt   (cnt),
        .o_free  (q_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_action         = res.action;
    assign o_out_xid        = res.xid;
    assign o_out_addr       = res.addr;
    assign o_out_server     = res.server;
    assign o_out_prefix_len = res.prefix_len;
    assign o_out_state      = res.state;
    assign o_out_lease_secs = res.lease_secs;
    assign o_last           = res.last;

    // a held transaction waits untouched until the queue takes it
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !take) |=> (r_in_valid && $stable(r_item)))
        else $error("input register changed while held");

endmodule
